// File: design/nfa_epsilon_closure_matcher_top_defines.svh
// assertion macros for the nfa matcher
`ifndef NFA_EPSILON_CLOSURE_MATCHER_TOP_DEFINES_SVH
`define NFA_EPSILON_CLOSURE_MATCHER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define NEC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define NEC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/nec_pkg.sv
// shared types and constants of the nfa matcher
`default_nettype none

package nec_pkg;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_SYMBOL = 2'd2;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_SYMBOL  = 2'd1;
    localparam logic [1:0] KIND_EPSILON = 2'd2;

    localparam logic CFG_START  = 1'b0;
    localparam logic CFG_ACCEPT = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_CLOS,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] sym;
        logic [5:0] t1;
        logic [5:0] t2;
        logic       t2_ok;
    } t_entry;

    typedef struct packed {
        logic       en;
        logic [5:0] addr;
        t_entry     data;
    } t_mem_wr;

    typedef struct packed {
        logic accepted;
        logic no_live;
    } t_result;

endpackage

`default_nettype wire

// File: design/nec_edge_mem.sv
// edge table memory, one write port and one registered read port
`default_nettype none

module nec_edge_mem #(
    parameter int NFA_STATES = 64
) (
    input  wire                             i_clk,
    input  nec_pkg::t_mem_wr                i_wr,
    input  wire                             i_rd_en,
    input  wire [$clog2(NFA_STATES)-1:0]    i_rd_addr,
    output nec_pkg::t_entry                 o_rd_data
);
    import nec_pkg::*;

    localparam int SW = $clog2(NFA_STATES);
    localparam int IW = (SW > 6) ? SW : 6;

    t_entry           r_mem [NFA_STATES];
    t_entry           r_rd_data;
    logic [IW-1:0]    wr_ext;

    assign wr_ext    = IW'(i_wr.addr);
    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[wr_ext[SW-1:0]] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: design/nec_seq.sv
// sequencer: active set, table sweeps and closure passes
`default_nettype none

module nec_seq #(
    parameter int NFA_STATES = 64
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire                             i_cfg_index,
    input  wire [5:0]                       i_cfg_data,
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  wire [1:0]                       i_op,
    input  wire [5:0]                       i_entry_index,
    input  wire [1:0]                       i_entry_kind,
    input  wire [7:0]                       i_edge_symbol,
    input  wire [5:0]                       i_first_target,
    input  wire [5:0]                       i_second_target,
    input  wire                             i_second_valid,
    input  wire [7:0]                       i_symbol,
    output nec_pkg::t_mem_wr                o_mem_wr,
    output logic                            o_rd_en,
    output logic [$clog2(NFA_STATES)-1:0]   o_rd_addr,
    input  nec_pkg::t_entry                 i_rd_data,
    input  wire                             i_out_free,
    output logic                            o_res_load,
    output nec_pkg::t_result                o_res
);
    import nec_pkg::*;
    `include "nfa_epsilon_closure_matcher_top_defines.svh"

    localparam int SW = $clog2(NFA_STATES);
    localparam int IW = (SW > 6) ? SW : 6;
    localparam logic [SW-1:0] LAST = SW'(NFA_STATES - 1);

    t_state                  r_state, n_state;
    logic                    r_issue, n_issue;
    logic [SW-1:0]           r_addr, n_addr;
    logic                    r_rvalid;
    logic [SW-1:0]           r_ridx;
    logic                    r_grew, n_grew;
    logic [NFA_STATES-1:0]   r_active, n_active;
    logic [NFA_STATES-1:0]   r_next, n_next;
    logic [7:0]              r_sym, n_sym;
    logic [5:0]              r_start_state;
    logic [5:0]              r_accept_state;
    logic                    in_accept;
    logic                    hit;
    logic                    grow_now;
    logic                    pass_end;

    function automatic logic f_inr(input logic [5:0] x);
        return ({26'd0, x} < 32'(NFA_STATES));
    endfunction

    function automatic logic [SW-1:0] f_idx(input logic [5:0] x);
        logic [IW-1:0] e;
        e = IW'(x);
        return e[SW-1:0];
    endfunction

    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign o_rd_en    = r_issue;
    assign o_rd_addr  = r_addr;
    assign hit        = r_rvalid && r_active[r_ridx];
    assign pass_end   = r_rvalid && (r_ridx == LAST);

    assign o_res.accepted = f_inr(r_accept_state) && r_active[f_idx(r_accept_state)];
    assign o_res.no_live  = ~|r_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_issue        <= 1'b0;
            r_addr         <= '0;
            r_rvalid       <= 1'b0;
            r_ridx         <= '0;
            r_grew         <= 1'b0;
            r_active       <= '0;
            r_start_state  <= '0;
            r_accept_state <= '0;
        end else begin
            r_state  <= n_state;
            r_issue  <= n_issue;
            r_addr   <= n_addr;
            r_rvalid <= r_issue;
            r_ridx   <= r_addr;
            r_grew   <= n_grew;
            r_active <= n_active;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_START) begin
                    r_start_state <= i_cfg_data;
                end else begin
                    r_accept_state <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_next <= n_next;
        r_sym  <= n_sym;
    end

    always_comb begin
        n_state       = r_state;
        n_issue       = r_issue;
        n_addr        = r_addr;
        n_grew        = r_grew;
        n_active      = r_active;
        n_next        = r_next;
        n_sym         = r_sym;
        o_mem_wr      = '0;
        o_res_load    = 1'b0;
        grow_now      = 1'b0;

        // address sweep advance
        if (r_issue) begin
            if (r_addr == LAST) begin
                n_issue = 1'b0;
            end else begin
                n_addr = r_addr + 1'b1;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    case (i_op)
                        OP_LOAD: begin
                            o_mem_wr.en        = f_inr(i_entry_index);
                            o_mem_wr.addr      = i_entry_index;
                            o_mem_wr.data.kind = i_entry_kind;
                            o_mem_wr.data.sym  = i_edge_symbol;
                            o_mem_wr.data.t1   = i_first_target;
                            o_mem_wr.data.t2   = i_second_target;
                            o_mem_wr.data.t2_ok = i_second_valid;
                            n_state = S_DONE;
                        end
                        OP_START: begin
                            n_active = '0;
                            if (f_inr(r_start_state)) begin
                                n_active[f_idx(r_start_state)] = 1'b1;
                            end
                            n_state = S_CLOS;
                            n_issue = 1'b1;
                            n_addr  = '0;
                            n_grew  = 1'b0;
                        end
                        OP_SYMBOL: begin
                            n_sym   = i_symbol;
                            n_next  = '0;
                            n_state = S_STEP;
                            n_issue = 1'b1;
                            n_addr  = '0;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_STEP: begin
                if (hit && (i_rd_data.kind == KIND_SYMBOL) && (i_rd_data.sym == r_sym)
                        && f_inr(i_rd_data.t1)) begin
                    n_next[f_idx(i_rd_data.t1)] = 1'b1;
                end
                if (pass_end) begin
                    n_active = n_next;
                    n_state  = S_CLOS;
                    n_issue  = 1'b1;
                    n_addr   = '0;
                    n_grew   = 1'b0;
                end
            end
            S_CLOS: begin
                if (hit && (i_rd_data.kind == KIND_EPSILON)) begin
                    if (f_inr(i_rd_data.t1) && !r_active[f_idx(i_rd_data.t1)]) begin
                        n_active[f_idx(i_rd_data.t1)] = 1'b1;
                        grow_now = 1'b1;
                    end
                    if (i_rd_data.t2_ok && f_inr(i_rd_data.t2)
                            && !r_active[f_idx(i_rd_data.t2)]) begin
                        n_active[f_idx(i_rd_data.t2)] = 1'b1;
                        grow_now = 1'b1;
                    end
                end
                n_grew = r_grew || grow_now;
                if (pass_end) begin
                    if (r_grew || grow_now) begin
                        n_issue = 1'b1;
                        n_addr  = '0;
                        n_grew  = 1'b0;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                o_res_load = i_out_free;
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `NEC_ASSERT_IMP(a_issue_busy, i_clk, i_rst_n, r_issue,
        (r_state == S_STEP) || (r_state == S_CLOS), "table read outside a sweep")
    `NEC_ASSERT_IMP(a_idle_quiet, i_clk, i_rst_n, r_state == S_IDLE,
        !r_issue && !r_rvalid, "sweep still running in idle")
    `NEC_ASSERT_IMP(a_empty_rejects, i_clk, i_rst_n, o_res_load && o_res.no_live,
        !o_res.accepted, "empty set reported as accepted")
    `NEC_ASSERT_NXT(a_done_leaves, i_clk, i_rst_n, (r_state == S_DONE) && i_out_free,
        r_state == S_IDLE, "result beat handed over but sequencer stayed done")

endmodule

`default_nettype wire

// File: design/nec_out.sv
// output register for result beats
`default_nettype none

module nec_out (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_load,
    input  nec_pkg::t_result    i_res,
    output logic                o_free,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output logic                o_accepted,
    output logic                o_no_live_state
);
    import nec_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free          = !r_valid || !i_out_stall;
    assign o_out_valid     = r_valid;
    assign o_accepted      = r_res.accepted;
    assign o_no_live_state = r_res.no_live;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

// File: design/nfa_epsilon_closure_matcher_top.sv
// a load entry or op three goes straight to the done state and then gives its result beat
// start and symbol items sweep the edge table; a symbol item first sweeps it for the symbol step
// then closure passes follow, 1 to N of them with N = NFA_STATES, one table read per cycle
// one item in flight at a time; the next item is taken once the result is registered
// reset clears control, config registers and the active set; the edge table is
// undefined until loaded
`default_nettype none

module nfa_epsilon_closure_matcher_top #(
    parameter int NFA_STATES = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_index,
    input  wire [5:0]   i_cfg_data,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire [1:0]   i_op,
    input  wire [5:0]   i_entry_index,
    input  wire [1:0]   i_entry_kind,
    input  wire [7:0]   i_edge_symbol,
    input  wire [5:0]   i_first_target,
    input  wire [5:0]   i_second_target,
    input  wire         i_second_valid,
    input  wire [7:0]   i_symbol,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic        o_accepted,
    output logic        o_no_live_state
);
    import nec_pkg::*;

    localparam int SW = $clog2(NFA_STATES);

    t_mem_wr        mem_wr;
    logic           rd_en;
    logic [SW-1:0]  rd_addr;
    t_entry         rd_data;
    logic           out_free;
    logic           res_load;
    t_result        res;

    nec_edge_mem #(
        .NFA_STATES (NFA_STATES)
    ) u_mem (
        .i_clk      (i_clk),
        .i_wr       (mem_wr),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .o_rd_data  (rd_data)
    );

    nec_seq #(
        .NFA_STATES (NFA_STATES)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_entry_index   (i_entry_index),
        .i_entry_kind    (i_entry_kind),
        .i_edge_symbol   (i_edge_symbol),
        .i_first_target  (i_first_target),
        .i_second_target (i_second_target),
        .i_second_valid  (i_second_valid),
        .i_symbol        (i_symbol),
        .o_mem_wr        (mem_wr),
        .o_rd_en         (rd_en),
        .o_rd_addr       (rd_addr),
        .i_rd_data       (rd_data),
        .i_out_free      (out_free),
        .o_res_load      (res_load),
        .o_res           (res)
    );

    nec_out u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (res_load),
        .i_res           (res),
        .o_free          (out_free),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_accepted      (o_accepted),
        .o_no_live_state (o_no_live_state)
    );

endmodule

`default_nettype wire

// File: bench/nfa_epsilon_closure_matcher_checker.sv
`timescale 1ns / 100ps
// active-set predictor and result checker for the nfa matcher
module nfa_epsilon_closure_matcher_checker #(
    parameter int NFA_STATES = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_index,
    input  wire [5:0]   i_cfg_data,
    input  wire         i_in_valid,
    input  wire         i_in_stall,
    input  wire [1:0]   i_op,
    input  wire [5:0]   i_entry_index,
    input  wire [1:0]   i_entry_kind,
    input  wire [7:0]   i_edge_symbol,
    input  wire [5:0]   i_first_target,
    input  wire [5:0]   i_second_target,
    input  wire         i_second_valid,
    input  wire [7:0]   i_symbol,
    input  wire         i_out_valid,
    input  wire         i_out_stall,
    input  wire         i_accepted,
    input  wire         i_no_live_state,
    output int          o_fail_count,
    output int          o_pending
);
    import nec_pkg::*;

    t_entry                 nfa_table [NFA_STATES];
    logic [NFA_STATES-1:0]  live_set = '0;
    logic [5:0]             start_reg = '0;
    logic [5:0]             accept_reg = '0;
    t_result                verdict_q [$];
    int                     fail_count = 0;

    function automatic logic [NFA_STATES-1:0] eps_close(input logic [NFA_STATES-1:0] seed);
        logic [NFA_STATES-1:0] reach;
        bit grew;
        reach = seed;
        grew = 1'b1;
        while (grew) begin
            grew = 1'b0;
            for (int k = 0; k < NFA_STATES; k++) begin
                if (reach[k] && nfa_table[k].kind == KIND_EPSILON) begin
                    if (int'(nfa_table[k].t1) < NFA_STATES && !reach[nfa_table[k].t1]) begin
                        reach[nfa_table[k].t1] = 1'b1;
                        grew = 1'b1;
                    end
                    if (nfa_table[k].t2_ok && int'(nfa_table[k].t2) < NFA_STATES
                            && !reach[nfa_table[k].t2]) begin
                        reach[nfa_table[k].t2] = 1'b1;
                        grew = 1'b1;
                    end
                end
            end
        end
        return reach;
    endfunction

    function automatic t_result step_active_set(input logic [1:0] op, input logic [5:0] idx,
                                                input t_entry ent, input logic [7:0] sym);
        logic [NFA_STATES-1:0] reached;
        t_result res;
        reached = '0;
        case (op)
            OP_LOAD: begin
                if (int'(idx) < NFA_STATES) nfa_table[idx] = ent;
            end
            OP_START: begin
                if (int'(start_reg) < NFA_STATES) reached[start_reg] = 1'b1;
                live_set = eps_close(reached);
            end
            OP_SYMBOL: begin
                for (int k = 0; k < NFA_STATES; k++) begin
                    if (live_set[k] && nfa_table[k].kind == KIND_SYMBOL && nfa_table[k].sym == sym
                            && int'(nfa_table[k].t1) < NFA_STATES)
                        reached[nfa_table[k].t1] = 1'b1;
                end
                live_set = eps_close(reached);
            end
            default: ;
        endcase
        res.accepted = (int'(accept_reg) < NFA_STATES) && live_set[accept_reg];
        res.no_live = (live_set == '0);
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        t_result fresh;
        t_entry ent;
        if (!i_rst_n) begin
            for (int k = 0; k < NFA_STATES; k++) nfa_table[k] = '0;
            live_set = '0;
            start_reg = '0;
            accept_reg = '0;
            verdict_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_START) start_reg = i_cfg_data;
                else accept_reg = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                got = '{accepted: i_accepted, no_live: i_no_live_state};
                if (verdict_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result beat, expected none, got accepted %0b no_live %0b",
                             $time, got.accepted, got.no_live);
                end else begin
                    want = verdict_q.pop_front();
                    if (got.accepted !== want.accepted) begin
                        fail_count++;
                        $display("%0t: accepted mismatch, expected %0b, got %0b",
                                 $time, want.accepted, got.accepted);
                    end
                    if (got.no_live !== want.no_live) begin
                        fail_count++;
                        $display("%0t: no_live_state mismatch, expected %0b, got %0b",
                                 $time, want.no_live, got.no_live);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                ent = '{kind: i_entry_kind, sym: i_edge_symbol, t1: i_first_target,
                        t2: i_second_target, t2_ok: i_second_valid};
                fresh = step_active_set(i_op, i_entry_index, ent, i_symbol);
                verdict_q = {verdict_q, fresh};
            end
        end
        o_fail_count <= fail_count;
        o_pending <= verdict_q.size();
    end

endmodule

// File: bench/nfa_epsilon_closure_matcher_top_test.sv
`timescale 1ns / 100ps
// stimulus, handshake pacing and verdict for the nfa matcher
module nfa_epsilon_closure_matcher_top_test;
    import nec_pkg::*;

    localparam int NFA_STATES = 64;
    localparam int RANDOM_BEATS = 600;
    localparam int TAIL_CYCLES = 4400;
    localparam int HOLD_CYCLES = 1500;
    localparam int TIMEOUT_NS = 120_000_000;
    localparam int ENTRY_W = $bits(t_entry);
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_index = 1'b0;
    logic [5:0] i_cfg_data = '0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [1:0] i_op = '0;
    logic [5:0] i_entry_index = '0;
    logic [1:0] i_entry_kind = '0;
    logic [7:0] i_edge_symbol = '0;
    logic [5:0] i_first_target = '0;
    logic [5:0] i_second_target = '0;
    logic       i_second_valid = 1'b0;
    logic [7:0] i_symbol = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic       o_accepted;
    logic       o_no_live_state;

    int         fail_count;
    int         pending_results;
    int         beats_sent = 0;
    int         burst_left = 0;
    int         hold_req = 0;
    logic [7:0] alphabet [4];

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    nfa_epsilon_closure_matcher_top #(
        .NFA_STATES(NFA_STATES)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_op(i_op),
        .i_entry_index(i_entry_index),
        .i_entry_kind(i_entry_kind),
        .i_edge_symbol(i_edge_symbol),
        .i_first_target(i_first_target),
        .i_second_target(i_second_target),
        .i_second_valid(i_second_valid),
        .i_symbol(i_symbol),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_accepted(o_accepted),
        .o_no_live_state(o_no_live_state)
    );

    nfa_epsilon_closure_matcher_checker #(
        .NFA_STATES(NFA_STATES)
    ) u_checker (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .i_in_stall(o_in_stall),
        .i_op(i_op),
        .i_entry_index(i_entry_index),
        .i_entry_kind(i_entry_kind),
        .i_edge_symbol(i_edge_symbol),
        .i_first_target(i_first_target),
        .i_second_target(i_second_target),
        .i_second_valid(i_second_valid),
        .i_symbol(i_symbol),
        .i_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .i_accepted(o_accepted),
        .i_no_live_state(o_no_live_state),
        .o_fail_count(fail_count),
        .o_pending(pending_results)
    );

    function automatic t_entry mk_entry(input logic [1:0] kind, input logic [7:0] sym,
                                        input logic [5:0] t1, input logic [5:0] t2,
                                        input logic t2_ok);
        return '{kind: kind, sym: sym, t1: t1, t2: t2, t2_ok: t2_ok};
    endfunction

    task automatic send_beat(input logic [1:0] op, input logic [5:0] idx, input t_entry ent,
                             input logic [7:0] sym);
        int gap;
        i_in_valid <= 1'b1;
        i_op <= op;
        i_entry_index <= idx;
        i_entry_kind <= ent.kind;
        i_edge_symbol <= ent.sym;
        i_first_target <= ent.t1;
        i_second_target <= ent.t2;
        i_second_valid <= ent.t2_ok;
        i_symbol <= sym;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        beats_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 12);
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 150) : $urandom_range(1, 4);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic load_entry(input logic [5:0] idx, input t_entry ent);
        send_beat(OP_LOAD, idx, ent, 8'($urandom));
    endtask

    task automatic send_op(input logic [1:0] op, input logic [7:0] sym);
        t_entry junk;
        junk = ENTRY_W'($urandom);
        send_beat(op, 6'($urandom), junk, sym);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [5:0] start_idx, input logic [5:0] accept_idx);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_START;
        i_cfg_data <= start_idx;
        @(posedge i_clk);
        i_cfg_index <= CFG_ACCEPT;
        i_cfg_data <= accept_idx;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // receiver: stall patterns in segments, plus long hold-offs on request
    initial begin : receiver_pattern
        int mode;
        int seg;
        int hold_served;
        hold_served = 0;
        forever begin
            if (hold_req != hold_served) begin
                hold_served = hold_req;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            mode = $urandom_range(0, 3);
            seg = $urandom_range(20, 200);
            repeat (seg) begin
                case (mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 7) == 0);
                    2: i_out_stall <= 1'($urandom_range(0, 1));
                    default: i_out_stall <= ~i_out_stall;
                endcase
                @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        int phase;
        int n;
        int r;
        logic [5:0] idx;
        logic [5:0] st;
        t_entry ent;
        phase = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every entry gets written before any start or symbol beat
        for (int k = 0; k < NFA_STATES; k++) begin
            ent = ENTRY_W'($urandom);
            ent.kind = KIND_NONE;
            load_entry(6'(k), ent);
        end

        // directed: reset config, empty set, op three, epsilon cycles and back chains
        send_op(OP_START, 8'h00);
        send_op(OP_SYMBOL, 8'h00);
        send_op(OP_SYMBOL, 8'hFF);
        send_beat(OP_UNUSED, 6'd63, mk_entry(KIND_UNUSED, 8'hFF, 6'd63, 6'd63, 1'b1), 8'hFF);
        load_entry(6'd0, mk_entry(KIND_EPSILON, 8'h00, 6'd63, 6'd5, 1'b1));
        load_entry(6'd63, mk_entry(KIND_SYMBOL, 8'hFF, 6'd0, 6'd63, 1'b1));
        load_entry(6'd5, mk_entry(KIND_SYMBOL, 8'h00, 6'd40, 6'd0, 1'b0));
        load_entry(6'd40, mk_entry(KIND_EPSILON, 8'hFF, 6'd30, 6'd63, 1'b0));
        load_entry(6'd30, mk_entry(KIND_EPSILON, 8'h00, 6'd20, 6'd30, 1'b1));
        load_entry(6'd20, mk_entry(KIND_EPSILON, 8'h00, 6'd21, 6'd20, 1'b1));
        load_entry(6'd21, mk_entry(KIND_UNUSED, 8'h00, 6'd0, 6'd0, 1'b1));
        send_op(OP_START, 8'h00);
        wait_drained();
        write_cfg(6'd63, 6'd21);
        send_op(OP_START, 8'h5A);
        send_op(OP_SYMBOL, 8'hFF);
        send_op(OP_SYMBOL, 8'h00);
        send_op(OP_SYMBOL, 8'h00);
        send_op(OP_START, 8'h00);
        send_op(OP_SYMBOL, 8'h7F);
        load_entry(6'd63, mk_entry(KIND_NONE, 8'hFF, 6'd0, 6'd0, 1'b0));
        wait_drained();
        write_cfg(6'd0, 6'd63);
        send_op(OP_START, 8'hFF);
        send_op(OP_SYMBOL, 8'hFF);

        while (beats_sent < RANDOM_BEATS) begin
            phase++;
            wait_drained();
            for (int k = 0; k < 4; k++) alphabet[k] = 8'($urandom);
            if ($urandom_range(0, 2) == 0) begin
                alphabet[0] = 8'h00;
                alphabet[3] = 8'hFF;
            end
            st = 6'($urandom);
            case ($urandom_range(0, 5))
                0: write_cfg(6'd0, 6'd0);
                1: write_cfg(6'd63, 6'd63);
                2: write_cfg(6'd0, 6'd63);
                3: write_cfg(6'd63, 6'd0);
                default: write_cfg(st, 6'(st + $urandom_range(1, 12)));
            endcase
            if (phase == 3 || phase == 9) hold_req <= hold_req + 1;
            if (phase == 1 || $urandom_range(0, 4) != 0) begin
                // mostly forward chains over a small alphabet so strings get deep
                n = (phase == 1) ? NFA_STATES : $urandom_range(4, 20);
                for (int k = 0; k < n; k++) begin
                    idx = (phase == 1) ? 6'(k) : 6'($urandom);
                    ent = ENTRY_W'($urandom);
                    r = $urandom_range(0, 99);
                    ent.kind = (r < 45) ? KIND_SYMBOL : (r < 80) ? KIND_EPSILON :
                               (r < 95) ? KIND_NONE : KIND_UNUSED;
                    ent.sym = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                          : alphabet[$urandom_range(0, 3)];
                    ent.t1 = ($urandom_range(0, 4) == 0) ? 6'($urandom)
                                                         : 6'(idx + $urandom_range(1, 4));
                    ent.t2 = ($urandom_range(0, 2) == 0) ? 6'(idx - $urandom_range(0, 3))
                                                         : 6'(idx + $urandom_range(1, 6));
                    load_entry(idx, ent);
                end
                repeat ($urandom_range(1, 4)) begin
                    send_op(OP_START, 8'($urandom));
                    repeat ($urandom_range(1, 14))
                        send_op(OP_SYMBOL, ($urandom_range(0, 6) == 0) ? 8'($urandom)
                                                                 : alphabet[$urandom_range(0, 3)]);
                end
            end else begin
                // noise: any op, fully random fields
                repeat ($urandom_range(4, 16)) begin
                    r = $urandom_range(0, 19);
                    ent = ENTRY_W'($urandom);
                    if (r == 0) send_beat(OP_UNUSED, 6'($urandom), ent, 8'($urandom));
                    else if (r < 8) load_entry(6'($urandom), ent);
                    else if (r < 12) send_op(OP_START, 8'($urandom));
                    else send_op(OP_SYMBOL, 8'($urandom));
                end
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_results == 0) begin
            $display("nfa_epsilon_closure_matcher_top test passed");
        end else begin
            $display("nfa_epsilon_closure_matcher_top test failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("nfa_epsilon_closure_matcher_top test failed");
        $finish;
    end

endmodule
